// ----- design/nrbo_pkg.sv -----
// Shared types and constants for the NV12 rectangle border overlay.
`default_nettype none

package nrbo_pkg;

  // Largest frame dimension; wider or taller frame settings saturate to it.
  localparam logic [12:0] MaxFrameDim = 13'd4096;

  localparam int unsigned CfgIndexWidth = 3;
  localparam int unsigned CfgDataWidth  = 24;

  // Configuration register indexes.
  typedef enum logic [CfgIndexWidth-1:0] {
    CfgFrameWidth      = 3'd0,
    CfgFrameHeight     = 3'd1,
    CfgRectLeft        = 3'd2,
    CfgRectTop         = 3'd3,
    CfgRectWidth       = 3'd4,
    CfgRectHeight      = 3'd5,
    CfgBorderRgb       = 3'd6,
    CfgBorderThickness = 3'd7
  } cfg_index_e;

  // One input item: the pixel coordinate under test.
  typedef struct packed {
    logic [11:0] pixel_col;
    logic [11:0] pixel_row;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic        on_border;
    logic [23:0] luma_address;
    logic [24:0] chroma_address;
    logic [7:0]  luma_value;
    logic [7:0]  cb_value;
    logic [7:0]  cr_value;
  } out_item_t;

  // Stage load enables and stage valid flags from the pipeline control.
  typedef struct packed {
    logic en1;
    logic en2;
    logic en3;
    logic v1;
    logic v2;
    logic v3;
  } pipe_ctl_t;

endpackage

`default_nettype wire

// ----- design/nrbo_pipe_ctrl.sv -----
// Valid bits and per-stage load enables of the three-stage pipeline.
`default_nettype none

module nrbo_pipe_ctrl import nrbo_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      out_stall_i,
  output pipe_ctl_t      ctl_o
);

  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;

  // A stage may load when it is empty or when its contents move on.
  assign en3 = !v3_q || !out_stall_i;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  // Valid bits travel with the item data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  assign ctl_o = '{en1: en1, en2: en2, en3: en3, v1: v1_q, v2: v2_q, v3: v3_q};

endmodule

`default_nettype wire

// ----- design/nrbo_geom.sv -----
// Border band test and NV12 luma and chroma address generation, three stages.
`default_nettype none

module nrbo_geom import nrbo_pkg::*; (
  input  wire logic        clk_i,
  input  wire pipe_ctl_t   ctl_i,
  input  wire in_item_t    item_i,
  input  wire logic [12:0] frame_width_i,
  input  wire logic [12:0] frame_height_i,
  input  wire logic [11:0] rect_left_i,
  input  wire logic [11:0] rect_top_i,
  input  wire logic [12:0] rect_width_i,
  input  wire logic [12:0] rect_height_i,
  input  wire logic [7:0]  thickness_i,
  output logic             on_border_o,
  output logic [23:0]      luma_address_o,
  output logic [24:0]      chroma_address_o
);

  // Stage 1 signals.
  logic [12:0] fw, fh;
  logic [13:0] right_edge, bottom_edge;
  logic        in_frame, in_rect, in_band;
  logic        hit1_d, hit1_q;
  logic [11:0] col1_q, row1_q;
  logic [12:0] fw1_q, fh1_q;

  // Stage 2 signals.
  logic [24:0] luma_prod_d, luma_prod_q;
  logic [23:0] chroma_prod_d, chroma_prod_q;
  logic [25:0] frame_prod_d, frame_prod_q;
  logic        hit2_q;
  logic [11:0] col2_q;

  // Stage 3 signals.
  logic [23:0] luma_addr_d, luma_addr_q;
  logic [24:0] chroma_addr_d, chroma_addr_q;
  logic        hit3_q;

  // Saturate the frame size and test the pixel against frame, rectangle and band.
  always_comb begin
    fw = (frame_width_i > MaxFrameDim) ? MaxFrameDim : frame_width_i;
    fh = (frame_height_i > MaxFrameDim) ? MaxFrameDim : frame_height_i;
    right_edge  = {2'b00, rect_left_i} + {1'b0, rect_width_i};
    bottom_edge = {2'b00, rect_top_i} + {1'b0, rect_height_i};
    in_frame = ({1'b0, item_i.pixel_col} < fw) && ({1'b0, item_i.pixel_row} < fh);
    in_rect  = (item_i.pixel_col >= rect_left_i) &&
               ({2'b00, item_i.pixel_col} < right_edge) &&
               (item_i.pixel_row >= rect_top_i) &&
               ({2'b00, item_i.pixel_row} < bottom_edge);
    // The right and bottom tests are moved across so that nothing goes negative.
    in_band  = ({1'b0, item_i.pixel_col} < ({1'b0, rect_left_i} + {5'b0, thickness_i})) ||
               (({2'b00, item_i.pixel_col} + {6'b0, thickness_i}) >= right_edge) ||
               ({1'b0, item_i.pixel_row} < ({1'b0, rect_top_i} + {5'b0, thickness_i})) ||
               (({2'b00, item_i.pixel_row} + {6'b0, thickness_i}) >= bottom_edge);
    hit1_d = in_frame && in_rect && in_band;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en1) begin
      hit1_q <= hit1_d;
      col1_q <= item_i.pixel_col;
      row1_q <= item_i.pixel_row;
      fw1_q  <= fw;
      fh1_q  <= fh;
    end
  end

  // Row offsets and the luma plane size.
  always_comb begin
    luma_prod_d   = 25'(row1_q) * 25'(fw1_q);
    chroma_prod_d = 24'(row1_q[11:1]) * 24'(fw1_q);
    frame_prod_d  = 26'(fw1_q) * 26'(fh1_q);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en2) begin
      luma_prod_q   <= luma_prod_d;
      chroma_prod_q <= chroma_prod_d;
      frame_prod_q  <= frame_prod_d;
      hit2_q        <= hit1_q;
      col2_q        <= col1_q;
    end
  end

  // Final address sums, masked to field width; zero off the border.
  always_comb begin
    luma_addr_d   = '0;
    chroma_addr_d = '0;
    if (hit2_q) begin
      luma_addr_d   = 24'(luma_prod_q + 25'(col2_q));
      chroma_addr_d = 25'(frame_prod_q + 26'(chroma_prod_q) +
                          26'({col2_q[11:1], 1'b0}));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en3) begin
      luma_addr_q   <= luma_addr_d;
      chroma_addr_q <= chroma_addr_d;
      hit3_q        <= hit2_q;
    end
  end

  assign on_border_o      = hit3_q;
  assign luma_address_o   = luma_addr_q;
  assign chroma_address_o = chroma_addr_q;

endmodule

`default_nettype wire

// ----- design/nrbo_color.sv -----
// RGB to YCbCr conversion of the border colour in Q16 fixed point, three stages.
`default_nettype none

module nrbo_color import nrbo_pkg::*; (
  input  wire logic        clk_i,
  input  wire pipe_ctl_t   ctl_i,
  input  wire logic [23:0] border_rgb_i,
  output logic [7:0]       luma_value_o,
  output logic [7:0]       cb_value_o,
  output logic [7:0]       cr_value_o
);

  // Coefficient magnitudes; signs are applied in the final sums.
  localparam logic [15:0] KYr  = 16'd19595;
  localparam logic [15:0] KYg  = 16'd38470;
  localparam logic [15:0] KYb  = 16'd7471;
  localparam logic [15:0] KCbr = 16'd11056;
  localparam logic [15:0] KCbg = 16'd21712;
  localparam logic [15:0] KCbb = 16'd32768;
  localparam logic [15:0] KCrr = 16'd32768;
  localparam logic [15:0] KCrg = 16'd27440;
  localparam logic [15:0] KCrb = 16'd5328;
  localparam logic signed [26:0] ChromaOffset = 27'sd8388608;

  logic [23:0] rgb1_q;
  logic [7:0]  red, grn, blu;
  logic [23:0] yr_d, yg_d, yb_d, cbr_d, cbg_d, cbb_d, crr_d, crg_d, crb_d;
  logic [23:0] yr_q, yg_q, yb_q, cbr_q, cbg_q, cbb_q, crr_q, crg_q, crb_q;
  logic signed [26:0] y_sum, cb_sum, cr_sum;
  logic [7:0]  y_d, cb_d, cr_d;
  logic [7:0]  y_q, cb_q, cr_q;

  // Truncate the Q16 sum and clamp it to 0..255.
  function automatic logic [7:0] clamp_q16(input logic signed [26:0] s);
    logic [7:0] v;
    if (s[26]) begin
      v = 8'd0;
    end else if (|s[25:24]) begin
      v = 8'hFF;
    end else begin
      v = s[23:16];
    end
    return v;
  endfunction

  // Stage 1 takes the colour with the item.
  always_ff @(posedge clk_i) begin
    if (ctl_i.en1) begin
      rgb1_q <= border_rgb_i;
    end
  end

  // Stage 2 forms the nine coefficient products.
  always_comb begin
    red   = rgb1_q[23:16];
    grn   = rgb1_q[15:8];
    blu   = rgb1_q[7:0];
    yr_d  = 24'(red) * 24'(KYr);
    yg_d  = 24'(grn) * 24'(KYg);
    yb_d  = 24'(blu) * 24'(KYb);
    cbr_d = 24'(red) * 24'(KCbr);
    cbg_d = 24'(grn) * 24'(KCbg);
    cbb_d = 24'(blu) * 24'(KCbb);
    crr_d = 24'(red) * 24'(KCrr);
    crg_d = 24'(grn) * 24'(KCrg);
    crb_d = 24'(blu) * 24'(KCrb);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en2) begin
      yr_q  <= yr_d;
      yg_q  <= yg_d;
      yb_q  <= yb_d;
      cbr_q <= cbr_d;
      cbg_q <= cbg_d;
      cbb_q <= cbb_d;
      crr_q <= crr_d;
      crg_q <= crg_d;
      crb_q <= crb_d;
    end
  end

  // Stage 3 adds with signs and offset, then clamps.
  always_comb begin
    y_sum  = $signed(27'(yr_q)) + $signed(27'(yg_q)) + $signed(27'(yb_q));
    cb_sum = $signed(27'(cbb_q)) - $signed(27'(cbr_q)) - $signed(27'(cbg_q)) +
             ChromaOffset;
    cr_sum = $signed(27'(crr_q)) - $signed(27'(crg_q)) - $signed(27'(crb_q)) +
             ChromaOffset;
    y_d  = clamp_q16(y_sum);
    cb_d = clamp_q16(cb_sum);
    cr_d = clamp_q16(cr_sum);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en3) begin
      y_q  <= y_d;
      cb_q <= cb_d;
      cr_q <= cr_d;
    end
  end

  assign luma_value_o = y_q;
  assign cb_value_o   = cb_q;
  assign cr_value_o   = cr_q;

endmodule

`default_nettype wire

// ----- design/nv12_rect_border_overlay.sv -----
// Top level of the NV12 rectangle border overlay: registers, pipeline and checks.
//
//   Channel   Direction  Handshake              Payload
//   in        input      in_valid_i/in_stall_o   in_item_i   (pixel_col, pixel_row)
//   out       output     out_valid_o/out_stall_i out_item_o  (border flag, addresses, YCbCr)
//   cfg       input      cfg_we_i                cfg_index_i, cfg_data_i
//
// An item passes three register stages: band test, address and colour products, final
// sums and clamp. The result is presented from the third stage with out_valid_o.
// One item can enter every cycle while the output is not stalled; the sustained rate is one item per cycle.
// Reset clears the stage valid bits and loads the configuration reset values.
// A stall on the output holds the last stage; earlier empty stages still fill.
`default_nettype none

module nv12_rect_border_overlay import nrbo_pkg::*; (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_stall_o,
  input  wire in_item_t                 in_item_i,
  output logic                          out_valid_o,
  input  wire logic                     out_stall_i,
  output out_item_t                     out_item_o,
  input  wire logic                     cfg_we_i,
  input  wire logic [CfgIndexWidth-1:0] cfg_index_i,
  input  wire logic [CfgDataWidth-1:0]  cfg_data_i
);

  logic [12:0] frame_width_q, frame_height_q, rect_width_q, rect_height_q;
  logic [11:0] rect_left_q, rect_top_q;
  logic [23:0] border_rgb_q;
  logic [7:0]  thickness_q;
  pipe_ctl_t   ctl;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= 13'd1920;
      frame_height_q <= 13'd1080;
      rect_left_q    <= '0;
      rect_top_q     <= '0;
      rect_width_q   <= '0;
      rect_height_q  <= '0;
      border_rgb_q   <= 24'h0000FF;
      thickness_q    <= 8'd5;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CfgFrameWidth:      frame_width_q  <= cfg_data_i[12:0];
        CfgFrameHeight:     frame_height_q <= cfg_data_i[12:0];
        CfgRectLeft:        rect_left_q    <= cfg_data_i[11:0];
        CfgRectTop:         rect_top_q     <= cfg_data_i[11:0];
        CfgRectWidth:       rect_width_q   <= cfg_data_i[12:0];
        CfgRectHeight:      rect_height_q  <= cfg_data_i[12:0];
        CfgBorderRgb:       border_rgb_q   <= cfg_data_i[23:0];
        CfgBorderThickness: thickness_q    <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // Pipeline control.
  nrbo_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .ctl_o       (ctl)
  );

  // Border test and addresses.
  nrbo_geom u_geom (
    .clk_i            (clk_i),
    .ctl_i            (ctl),
    .item_i           (in_item_i),
    .frame_width_i    (frame_width_q),
    .frame_height_i   (frame_height_q),
    .rect_left_i      (rect_left_q),
    .rect_top_i       (rect_top_q),
    .rect_width_i     (rect_width_q),
    .rect_height_i    (rect_height_q),
    .thickness_i      (thickness_q),
    .on_border_o      (out_item_o.on_border),
    .luma_address_o   (out_item_o.luma_address),
    .chroma_address_o (out_item_o.chroma_address)
  );

  // Border colour conversion.
  nrbo_color u_color (
    .clk_i        (clk_i),
    .ctl_i        (ctl),
    .border_rgb_i (border_rgb_q),
    .luma_value_o (out_item_o.luma_value),
    .cb_value_o   (out_item_o.cb_value),
    .cr_value_o   (out_item_o.cr_value)
  );

  assign in_stall_o  = !ctl.en1;
  assign out_valid_o = ctl.v3;

`ifndef NO_ASSERTIONS
  // Input is held back only when every stage is full and the output is stalled.
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (ctl.v1 && ctl.v2 && ctl.v3 && out_stall_i))
    else $error("input stalled while the pipeline has room");

  // A result off the border carries zero addresses.
  a_off_border_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.on_border) |->
      (out_item_o.luma_address == '0 && out_item_o.chroma_address == '0))
    else $error("nonzero address on a result off the border");

  // An item accepted into an empty pipeline moves on from the first stage into the second unless the output stalls.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !out_stall_i && !ctl.v1 && !ctl.v2 && !ctl.v3)
      |=> ##1 (ctl.v2 || out_stall_i || $past(out_stall_i)))
    else $error("accepted item did not advance through the pipeline");
`endif

endmodule

`default_nettype wire
